// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, idle during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/rzs_pkg.sv =====
// Shared types and constants for the ratio z-score signal block
package rzs_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int PRICE_W     = 32;
    localparam int RATIO_W     = 32;
    localparam int SUM_W       = 64;
    localparam int THR_W       = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] SIG_NONE  = 2'b00;
    localparam logic [1:0] SIG_LONG  = 2'b01;
    localparam logic [1:0] SIG_SHORT = 2'b11;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_ACC, ST_FIN, ST_MEAN, ST_EX2, ST_VAR, ST_SQRT,
        ST_RD, ST_CMP, ST_OUT
    } state_t;

    typedef struct packed {
        logic start_div;   // ratio divide for a sample
        logic acc;         // store and accumulate ratio
        logic clear;       // new series
        logic start_mean;  // sum / count
        logic start_ex2;   // square sum / count
        logic set_var;     // form variance
        logic start_sqrt;
        logic close;       // latch phase = signalling
        logic rd;          // issue store read
        logic cmp;         // evaluate signal into output reg
        logic ptr_inc;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic phase;
        logic store_full;
        logic fetch_ok;
    } stat_t;
endpackage

// ===== src/ratio_zscore_signal.sv =====
// Top level of the ratio z-score signal generator
// Usage:
//  s_ channel: tuser = cmd (0 load, 1 fetch), tlast = final sample,
//  tdata = {price_second, price_first}, price_first in bits 31:0.
//  A load forms a Q16.16 ratio with a 64-step restoring divider and
//  accumulates it; the next load is taken once it is stored. The final
//  sample then closes the series: two more 64-step divides and a 32-step
//  root. A zero divisor skips the divide. A load into a full store is
//  dropped; a final one still closes the series. A fetch reads the ratio
//  store, and the compare step raises m_tvalid; the next fetch is taken
//  once that step is done. A fetch with nothing left gives no result.
//  m_ channel: tdata = {degenerate, final_signal, sample_index, signal},
//  signal in bits 1:0, zero-padded to 16 bits.
//  The divider, the root unit and the single store port set the rate; one
//  transaction is processed at a time.
//  Reset (aresetn low, synchronous) clears sums, pointer, phase, flag and
//  sets the threshold to 2.0. The store holds no reset value.
//  When m_tready is low the result holds; loads go on, a fetch waits at the
//  compare step and the input stalls behind it. cfg_wr_en/cfg_wr_data write the
//  Q8.8 entry threshold; the user must do so while idle, the block does not check.
`include "assert_macros.svh"
module ratio_zscore_signal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // price_first, price_second
    input  logic        s_tuser,  // cmd
    input  logic        s_tlast,  // final_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // signal, sample_index, final_signal, degenerate
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import rzs_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  out_free;
    logic [1:0] sig;
    logic [ADDR_W-1:0] idx;
    logic fin, deg;

    rzs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_cmd(s_tuser), .in_last(s_tlast), .out_free(out_free),
        .stat(stat), .cmd(cmd)
    );

    rzs_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .price_first(s_tdata[31:0]), .price_second(s_tdata[63:32]),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .out_free(out_free), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_signal(sig), .m_index(idx), .m_final(fin), .m_degen(deg)
    );

    assign m_tdata = {2'b00, deg, fin, idx, sig};

    `ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPL(a_sig_legal, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'b10)
    `ASSERT_NEXT(a_cmp_valid, aclk, aresetn, cmd.cmp, m_tvalid)
endmodule

// ===== src/rzs_ram.sv =====
// Generic single-port RAM with registered read
module rzs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/rzs_ctrl.sv =====
// Sequencer for load, close and fetch transactions
module rzs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           in_cmd,
    input  logic           in_last,
    input  logic           out_free,
    input  rzs_pkg::stat_t stat,
    output rzs_pkg::cmd_t  cmd
);
    import rzs_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_cmd == CMD_LOAD) begin
                        last_next = in_last;
                        cmd.clear = stat.phase;
                        if (stat.store_full && !stat.phase) begin
                            if (in_last) begin
                                cmd.start_mean = 1'b1;
                                state_next = ST_MEAN;
                            end
                        end else begin
                            cmd.start_div = 1'b1;
                            state_next = ST_DIV;
                        end
                    end else if (stat.fetch_ok) begin
                        cmd.rd = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_DIV: if (stat.div_done) begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            // sums hold the last sample from here on
            ST_FIN: begin
                cmd.start_mean = 1'b1;
                state_next = ST_MEAN;
            end
            ST_MEAN: if (stat.div_done) begin
                cmd.start_ex2 = 1'b1;
                state_next = ST_EX2;
            end
            ST_EX2: if (stat.div_done) begin
                state_next = ST_VAR;
            end
            ST_VAR: begin
                cmd.set_var = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.start_sqrt = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (stat.sqrt_done) begin
                cmd.close = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD: state_next = ST_CMP;
            // wait here while the previous result is still held
            ST_CMP: if (out_free) begin
                cmd.cmp = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== src/rzs_dp.sv =====
// Datapath: divider, root unit, sums, ratio store and signal compare
module rzs_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rzs_pkg::cmd_t             cmd,
    output rzs_pkg::stat_t            stat,
    input  logic [rzs_pkg::PRICE_W-1:0] price_first,
    input  logic [rzs_pkg::PRICE_W-1:0] price_second,
    input  logic                      cfg_wr_en,
    input  logic [rzs_pkg::THR_W-1:0] cfg_wr_data,
    output logic                      out_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_signal,
    output logic [rzs_pkg::ADDR_W-1:0] m_index,
    output logic                      m_final,
    output logic                      m_degen
);
    import rzs_pkg::*;

    // shared restoring divider: 64-bit dividend / 32-bit divisor, one bit per cycle
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic        dbusy_reg, dbusy_next;
    logic [64:0] rem_sh;

    logic [THR_W-1:0]   thr_reg;
    logic [63:0]        sum_reg, sq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W:0]    ptr_reg;
    logic [RATIO_W-1:0] mean_reg, dev_reg;
    logic               phase_reg, err_reg;
    logic [63:0]        mean_sq_reg;
    logic [47:0]        var_reg;

    // sqrt
    logic [63:0] sv_reg, sres_reg, sbit_reg;
    logic        sbusy_reg;

    logic [RATIO_W-1:0] rd_data;
    logic        we;
    logic [ADDR_W-1:0] addr;

    logic [RATIO_W-1:0] mean_c;
    logic [63:0]        mean_sq_full;

    assign mean_c       = (quo_reg[63:32] != '0) ? '1 : quo_reg[31:0];
    assign mean_sq_full = mean_c * mean_c;

    always_comb begin
        rem_sh     = {rem_reg[63:0], dvd_reg[63]};
        dvd_next   = {dvd_reg[62:0], 1'b0};
        rem_next   = rem_sh;
        quo_next   = {quo_reg[62:0], 1'b0};
        if (rem_sh >= {32'd0, dvs_reg}) begin
            rem_next    = rem_sh - {32'd0, dvs_reg};
            quo_next[0] = 1'b1;
        end
        dcnt_next  = dcnt_reg - 7'd1;
        dbusy_next = (dcnt_reg != 7'd1);
    end

    assign stat.div_done = !dbusy_reg;
    assign stat.sqrt_done = !sbusy_reg;
    assign stat.phase = phase_reg;
    assign stat.store_full = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign stat.fetch_ok = phase_reg && ({1'b0, ptr_reg} < {1'b0, cnt_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            sbusy_reg <= 1'b0;
            thr_reg   <= THR_W'(512);
            sum_reg   <= '0;
            sq_reg    <= '0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            mean_reg  <= '0;
            dev_reg   <= '0;
            phase_reg <= 1'b0;
            err_reg   <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            if (cfg_wr_en) thr_reg <= cfg_wr_data;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.clear) begin
                sum_reg <= '0; sq_reg <= '0; cnt_reg <= '0; ptr_reg <= '0;
                err_reg <= 1'b0; phase_reg <= 1'b0; mean_reg <= '0; dev_reg <= '0;
            end
            if (cmd.start_div) begin
                dvd_reg   <= {16'd0, price_first, 16'd0};
                dvs_reg   <= {1'b0, price_second};
                rem_reg   <= '0;
                quo_reg   <= '0;
                dcnt_reg  <= 7'd64;
                dbusy_reg <= (price_second != '0);
                if (price_second == '0) begin
                    quo_reg <= 64'hFFFF_FFFF;
                    err_reg <= 1'b1;
                end
            end else if (cmd.start_mean || cmd.start_ex2) begin
                dvd_reg   <= cmd.start_mean ? sum_reg : sq_reg;
                dvs_reg   <= {{(33-CNT_W){1'b0}}, cnt_reg};
                rem_reg   <= '0;
                quo_reg   <= '0;
                dcnt_reg  <= 7'd64;
                dbusy_reg <= (cnt_reg != '0);
                if (cmd.start_ex2) begin
                    mean_reg <= mean_c;
                end
            end else if (dbusy_reg) begin
                dvd_reg   <= dvd_next;
                rem_reg   <= rem_next;
                quo_reg   <= quo_next;
                dcnt_reg  <= dcnt_next;
                dbusy_reg <= dbusy_next;
            end
            if (cmd.acc) begin
                sum_reg <= sum_reg + {32'd0, ratio_reg_in(quo_reg)};
                sq_reg  <= sq_sum_sat(sq_reg, quo_reg);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.start_ex2) begin
                mean_sq_reg <= {16'd0, mean_sq_full[63:16]};
            end
            if (cmd.set_var) begin
                var_reg <= (cnt_reg == '0) ? '0 :
                    (quo_reg > mean_sq_reg) ?
                        (((quo_reg - mean_sq_reg) > 64'hFFFF_FFFF_FFFF) ?
                            48'hFFFF_FFFF_FFFF : 48'(quo_reg - mean_sq_reg)) : '0;
                if (cnt_reg == '0) mean_reg <= '0;
            end
            if (cmd.start_sqrt) begin
                sv_reg    <= {var_reg, 16'd0};
                sres_reg  <= '0;
                sbit_reg  <= 64'd1 << 62;
                sbusy_reg <= 1'b1;
            end else if (sbusy_reg) begin
                if (sv_reg >= sres_reg + sbit_reg) begin
                    sv_reg   <= sv_reg - (sres_reg + sbit_reg);
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
                if (sbit_reg[0]) sbusy_reg <= 1'b0;
            end
            if (cmd.close) begin
                dev_reg   <= sres_reg[31:0];
                ptr_reg   <= '0;
                phase_reg <= 1'b1;
            end
            if (cmd.ptr_inc) ptr_reg <= ptr_reg + 1'b1;
            if (cmd.cmp) m_valid <= 1'b1;
        end
    end

    function automatic logic [31:0] ratio_reg_in(input logic [63:0] q);
        ratio_reg_in = (q[63:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [63:0] sq_sum_sat(input logic [63:0] s,
                                               input logic [63:0] q);
        logic [31:0] r;
        logic [63:0] p;
        logic [64:0] a;
        r = ratio_reg_in(q);
        p = r * r;
        a = {1'b0, s} + {17'd0, p[63:16]};
        sq_sum_sat = a[64] ? '1 : a[63:0];
    endfunction

    assign we   = cmd.acc;
    assign addr = cmd.acc ? cnt_reg[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];

    rzs_ram #(.WIDTH(RATIO_W), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (ratio_reg_in(quo_reg)),
        .rdata (rd_data)
    );

    // signal compare: (r - mean)*256 vs thr*dev, thr*dev needs 48 bits
    logic signed [32:0] diff;
    logic [47:0]        thr_dev;
    logic signed [49:0] lhs, rhs;
    assign diff    = signed'({1'b0, rd_data}) - signed'({1'b0, mean_reg});
    assign lhs     = {{9{diff[32]}}, diff, 8'd0};
    assign thr_dev = thr_reg * dev_reg;
    assign rhs     = signed'({2'b00, thr_dev});

    always_ff @(posedge aclk) begin
        if (cmd.cmp) begin
            m_signal <= (lhs > rhs) ? SIG_SHORT : ((lhs < -rhs) ? SIG_LONG : SIG_NONE);
            m_index  <= ptr_reg[ADDR_W-1:0];
            m_final  <= ({1'b0, ptr_reg} + 1'b1 == {1'b0, cnt_reg});
            m_degen  <= err_reg || (dev_reg == '0);
        end
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid || m_ready;
endmodule
